@@ src/bcs_pkg.sv @@
// ----------------------------------------------------------------------------
// bcs_pkg
// Types and constants shared by the best-class seed selector.
// ----------------------------------------------------------------------------
package bcs_pkg;

    localparam int MAX_ANCHORS  = 16384;
    localparam int MAX_CLASSES  = 128;
    localparam int MAX_SEEDS    = 4096;

    localparam int ANCHOR_W     = 14;
    localparam int CLASS_W      = 7;
    localparam int LOGIT_W      = 8;
    localparam int SCORE_W      = 16;
    localparam int COUNT_W      = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int TABLE_ADDR_W = 8;

    typedef enum logic [1:0] {
        MODE_FRAME = 2'd0,
        MODE_LOGIT = 2'd1,
        MODE_TABLE = 2'd2,
        MODE_SPARE = 2'd3
    } mode_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_PASS_MIN      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESCREEN_MIN = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEED_CAPACITY = 2'd2;

    localparam logic [0:0] STATUS_SEED     = 1'b0;
    localparam logic [0:0] STATUS_OVERFLOW = 1'b1;

    typedef struct packed {
        logic [1:0]                 mode;
        logic [ANCHOR_W-1:0]        anchor_index;
        logic [CLASS_W-1:0]         class_index;
        logic signed [LOGIT_W-1:0]  logit_value;
        logic                       last_class;
        logic signed [LOGIT_W-1:0]  prescreen_sum;
        logic [SCORE_W-1:0]         table_word;
    } in_item_t;

    typedef struct packed {
        logic [ANCHOR_W-1:0]        seed_anchor;
        logic [CLASS_W-1:0]         seed_class;
        logic signed [LOGIT_W-1:0]  seed_logit;
        logic [SCORE_W-1:0]         seed_score;
        logic                       status;
    } out_item_t;

endpackage

@@ src/bcs_stream_if.sv @@
// ----------------------------------------------------------------------------
// bcs_in_if / bcs_out_if
// Valid/ready channels carrying logit items in and seed items out.
// ----------------------------------------------------------------------------
interface bcs_in_if;
    import bcs_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bcs_out_if;
    import bcs_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/bcs_score_ram.sv @@
// ----------------------------------------------------------------------------
// bcs_score_ram
// 256 x 16 sigmoid table, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bcs_score_ram (
    input  logic                               clk,
    input  logic                               we,
    input  logic [bcs_pkg::TABLE_ADDR_W-1:0]   waddr,
    input  logic [bcs_pkg::SCORE_W-1:0]        wdata,
    input  logic                               re,
    input  logic [bcs_pkg::TABLE_ADDR_W-1:0]   raddr,
    output logic [bcs_pkg::SCORE_W-1:0]        rdata
);
    import bcs_pkg::*;

    logic [SCORE_W-1:0] mem [2**TABLE_ADDR_W];
    logic [SCORE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/int8_best_class_seed_selector.sv @@
// ----------------------------------------------------------------------------
// int8_best_class_seed_selector
// Running argmax over the class logits of each anchor, threshold test,
// seed capacity tracking and sigmoid table lookup of the winning logit.
// ----------------------------------------------------------------------------
// output: a seed is registered when the anchor's last class element is accepted
//   and is valid in the next cycle (the table read shares that output register)
// throughput: one item per cycle while the seed output is not stalled, set by the single compare-and-keep update
// reset: clears best logit/class, seed count, overflow flag and the output
//   valid flag; the sigmoid table is not cleared and must be loaded by software
module int8_best_class_seed_selector (
    input  logic                              clk,
    input  logic                              rst_n,
    bcs_in_if.sink                            item,
    bcs_out_if.source                         seed,
    input  logic                              cfg_we,
    input  logic [bcs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bcs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bcs_pkg::*;

    logic signed [8:0]         pass_min_reg;
    logic signed [LOGIT_W-1:0] prescreen_min_reg;
    logic [COUNT_W-1:0]        seed_capacity_reg;

    logic signed [LOGIT_W-1:0] best_logit_reg, best_logit_next;
    logic [CLASS_W-1:0]        lead_class_reg, lead_class_next;
    logic [COUNT_W-1:0]        seed_count_reg, seed_count_next;
    logic                      overflowed_reg, overflowed_next;

    logic                      out_valid_reg, out_valid_next;
    logic [ANCHOR_W-1:0]       anchor_reg;
    logic [CLASS_W-1:0]        class_reg;
    logic signed [LOGIT_W-1:0] logit_reg;
    logic                      status_reg;

    logic                      accept;
    logic                      is_elem;
    logic                      take;
    logic signed [LOGIT_W-1:0] cand_logit;
    logic [CLASS_W-1:0]        cand_class;
    logic                      passes;
    logic [COUNT_W-1:0]        cap_eff;
    logic                      full;
    logic                      emit;
    logic                      emit_ovf;
    logic [SCORE_W-1:0]        table_data;

    assign item.ready = !out_valid_reg || seed.ready;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        is_elem    = (item.data.mode == MODE_LOGIT) && !overflowed_reg;
        take       = (item.data.class_index == '0) ||
                     ($signed(item.data.logit_value) > best_logit_reg);
        cand_logit = take ? $signed(item.data.logit_value) : best_logit_reg;
        cand_class = take ? item.data.class_index : lead_class_reg;
        passes     = ($signed(item.data.prescreen_sum) >= prescreen_min_reg) &&
                     ($signed({cand_logit[LOGIT_W-1], cand_logit}) >= pass_min_reg);
        cap_eff    = (seed_capacity_reg > COUNT_W'(MAX_SEEDS)) ?
                     COUNT_W'(MAX_SEEDS) : seed_capacity_reg;
        full       = seed_count_reg >= cap_eff;
        emit       = accept && is_elem && item.data.last_class && passes;
        emit_ovf   = emit && full;

        best_logit_next = best_logit_reg;
        lead_class_next = lead_class_reg;
        seed_count_next = seed_count_reg;
        overflowed_next = overflowed_reg;

        if (accept)
        begin
            case (item.data.mode)
                MODE_FRAME:
                begin
                    best_logit_next = -8'sd128;
                    lead_class_next = '0;
                    seed_count_next = '0;
                    overflowed_next = 1'b0;
                end
                MODE_LOGIT:
                begin
                    if (is_elem)
                    begin
                        if (item.data.last_class)
                        begin
                            best_logit_next = -8'sd128;
                            lead_class_next = '0;
                        end
                        else
                        begin
                            best_logit_next = cand_logit;
                            lead_class_next = cand_class;
                        end
                    end
                    if (emit_ovf)
                    begin
                        overflowed_next = 1'b1;
                    end
                    else if (emit)
                    begin
                        seed_count_next = seed_count_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (accept)
        begin
            out_valid_next = emit;
        end
        else if (seed.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_min_reg      <= 9'sd128;
            prescreen_min_reg <= -8'sd128;
            seed_capacity_reg <= COUNT_W'(MAX_SEEDS);
            best_logit_reg    <= -8'sd128;
            lead_class_reg    <= '0;
            seed_count_reg    <= '0;
            overflowed_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PASS_MIN:      pass_min_reg      <= $signed(cfg_data[8:0]);
                    CFG_PRESCREEN_MIN: prescreen_min_reg <= $signed(cfg_data[7:0]);
                    CFG_SEED_CAPACITY: seed_capacity_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            best_logit_reg <= best_logit_next;
            lead_class_reg <= lead_class_next;
            seed_count_reg <= seed_count_next;
            overflowed_reg <= overflowed_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload only loads with a new result, so it holds while stalled
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            anchor_reg <= emit_ovf ? '0 : item.data.anchor_index;
            class_reg  <= emit_ovf ? '0 : cand_class;
            logit_reg  <= emit_ovf ? '0 : cand_logit;
            status_reg <= emit_ovf ? STATUS_OVERFLOW : STATUS_SEED;
        end
    end

    // the 8-bit logit pattern addresses the table for writes and reads
    bcs_score_ram u_score_ram (
        .clk   (clk),
        .we    (accept && (item.data.mode == MODE_TABLE)),
        .waddr (item.data.logit_value),
        .wdata (item.data.table_word),
        .re    (emit),
        .raddr (cand_logit),
        .rdata (table_data)
    );

    assign seed.valid            = out_valid_reg;
    assign seed.data.seed_anchor = anchor_reg;
    assign seed.data.seed_class  = class_reg;
    assign seed.data.seed_logit  = logit_reg;
    assign seed.data.seed_score  = (status_reg == STATUS_OVERFLOW) ? '0 : table_data;
    assign seed.data.status      = status_reg;

endmodule

@@ src/bcs_checker.sv @@
// ----------------------------------------------------------------------------
// bcs_checker
// Port-level checks for the best-class seed selector, bound to the top level.
// ----------------------------------------------------------------------------
module bcs_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  bcs_pkg::in_item_t   in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  bcs_pkg::out_item_t  out_data
);
    import bcs_pkg::*;

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled seed changed");

    // overflow status carries an all-zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |->
            out_data.seed_anchor == '0 && out_data.seed_class == '0 &&
            out_data.seed_logit == '0 && out_data.seed_score == '0)
    else $error("overflow status with nonzero payload");

    // only a last class element may produce a result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready &&
            !(in_data.mode == MODE_LOGIT && in_data.last_class) |=> !out_valid)
    else $error("result from an item that cannot produce one");

    // an empty output stage never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind int8_best_class_seed_selector bcs_checker u_bcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_data   (item.data),
    .out_valid (seed.valid),
    .out_ready (seed.ready),
    .out_data  (seed.data)
);
